@@ hw/rtl/spq_pkg.sv @@
// Shared types and constants for the stable priority queue.
package spq_pkg;

   localparam int TAG_W  = 16;
   localparam int AGE_W  = 8;
   localparam int PRIO_W = 8;
   localparam int OCC_W  = 5;
   localparam int STAT_W = 2;

   // Entries of the command queue between the front and back parts
   localparam int CMD_FIFO_DEPTH = 2;

   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [AGE_W-1:0]  age;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   typedef struct packed {
      op_type    op;
      entry_type entry;
   } cmd_type;

endpackage

@@ hw/rtl/spq_front.sv @@
// Request front end: takes request transfers and decodes them into commands.
module spq_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_type,
   input  logic [spq_pkg::TAG_W-1:0]   req_entry_tag,
   input  logic [spq_pkg::AGE_W-1:0]   req_entry_age,
   input  logic [spq_pkg::PRIO_W-1:0]  req_entry_priority,
   output logic                        cmd_valid,
   input  logic                        cmd_ready,
   output spq_pkg::cmd_type            cmd
);

   logic             front_valid_ff;
   logic             front_valid_in;
   spq_pkg::cmd_type front_cmd_ff;
   spq_pkg::cmd_type front_cmd_in;
   logic             take;

   assign req_ready = !front_valid_ff || cmd_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      front_cmd_in.op         = spq_pkg::op_type'(req_type);
      front_cmd_in.entry.tag  = req_entry_tag;
      front_cmd_in.entry.age  = req_entry_age;
      front_cmd_in.entry.prio = req_entry_priority;
      front_valid_in          = take || (front_valid_ff && !cmd_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         front_cmd_ff <= front_cmd_in;
      end
   end

   assign cmd_valid = front_valid_ff;
   assign cmd       = front_cmd_ff;

endmodule

@@ hw/rtl/spq_cmd_fifo.sv @@
// Short command queue between the front end and the slot array.
module spq_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  spq_pkg::cmd_type in_cmd,
   output logic             out_valid,
   input  logic             out_ready,
   output spq_pkg::cmd_type out_cmd
);

   localparam int Depth = spq_pkg::CMD_FIFO_DEPTH;
   localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW  = $clog2(Depth + 1);

   spq_pkg::cmd_type mem_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             push, pop;

   assign in_ready  = count_ff != CntW'(Depth);
   assign out_valid = count_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_cmd   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

@@ hw/rtl/spq_back.sv @@
// Sorted slot array: executes insert/remove commands and registers the result.
module spq_back #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cmd_valid,
   output logic                        cmd_ready,
   input  spq_pkg::cmd_type            cmd,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_served_valid,
   output logic [spq_pkg::TAG_W-1:0]   rsp_served_tag,
   output logic [spq_pkg::AGE_W-1:0]   rsp_served_age,
   output logic [spq_pkg::PRIO_W-1:0]  rsp_served_priority,
   output logic [spq_pkg::OCC_W-1:0]   rsp_occupancy,
   output logic [spq_pkg::STAT_W-1:0]  rsp_status
);

   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   spq_pkg::entry_type slot_ff [QUEUE_DEPTH];
   spq_pkg::entry_type up_entry [QUEUE_DEPTH];
   spq_pkg::entry_type dn_entry [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] go;
   logic [QUEUE_DEPTH-1:0] go_prev;

   logic [CntW-1:0] count_ff, count_in;
   logic            do_op, full, empty, do_insert, do_remove;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       served_valid_ff, served_valid_in;
   spq_pkg::entry_type         served_ff, served_in;
   logic [spq_pkg::OCC_W-1:0]  occ_ff, occ_in;
   spq_pkg::status_type        status_ff, status_in;

   assign cmd_ready = !rsp_valid_ff || rsp_ready;
   assign do_op     = cmd_valid && cmd_ready;
   assign full      = count_ff == CntW'(QUEUE_DEPTH);
   assign empty     = count_ff == '0;
   assign do_insert = do_op && (cmd.op == spq_pkg::OP_INSERT) && !full;
   assign do_remove = do_op && (cmd.op == spq_pkg::OP_REMOVE) && !empty;

   // go marks slots at or past the insertion point; monotone since slots are sorted
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         go[i] = (CntW'(i) >= count_ff) || (slot_ff[i].prio < cmd.entry.prio);
      end
   end
   assign go_prev = {go[QUEUE_DEPTH-2:0], 1'b0};

   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_nbr
      if (g == 0) begin : g_head
         assign up_entry[g] = cmd.entry;
      end else begin : g_up
         assign up_entry[g] = slot_ff[g-1];
      end
      if (g == QUEUE_DEPTH - 1) begin : g_tail
         assign dn_entry[g] = slot_ff[g];
      end else begin : g_dn
         assign dn_entry[g] = slot_ff[g+1];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (do_insert && go[i]) begin
            slot_ff[i] <= go_prev[i] ? up_entry[i] : cmd.entry;
         end else if (do_remove) begin
            slot_ff[i] <= dn_entry[i];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (do_insert) begin
         count_in = count_ff + 1'b1;
      end else if (do_remove) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in    = do_op || (rsp_valid_ff && !rsp_ready);
      served_valid_in = do_remove;
      served_in       = do_remove ? slot_ff[0] : '0;
      occ_in          = spq_pkg::OCC_W'(count_in);
      status_in       = spq_pkg::ST_OK;
      if (cmd.op == spq_pkg::OP_INSERT && full) begin
         status_in = spq_pkg::ST_FULL;
      end else if (cmd.op == spq_pkg::OP_REMOVE && empty) begin
         status_in = spq_pkg::ST_EMPTY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_op) begin
         served_valid_ff <= served_valid_in;
         served_ff       <= served_in;
         occ_ff          <= occ_in;
         status_ff       <= status_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_served_valid    = served_valid_ff;
   assign rsp_served_tag      = served_ff.tag;
   assign rsp_served_age      = served_ff.age;
   assign rsp_served_priority = served_ff.prio;
   assign rsp_occupancy       = occ_ff;
   assign rsp_status          = status_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(QUEUE_DEPTH))
      else $error("held count above queue depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      do_insert |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not grow held count");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CntW'(2) |-> slot_ff[0].prio >= slot_ff[1].prio)
      else $error("head slots out of order");

   a_empty_remove: assert property (@(posedge clock) disable iff (reset)
      do_op && cmd.op == spq_pkg::OP_REMOVE && empty
      |=> status_ff == spq_pkg::ST_EMPTY && !served_valid_ff)
      else $error("remove on empty queue misreported");
`endif

endmodule

@@ hw/rtl/stable_priority_queue_top.sv @@
// Stable bounded priority queue: front end, command queue and sorted slot array.
//
// Requests arrive on the req_ channel (valid/ready). req_type 0 inserts the
// entry (tag, age, priority); 1 removes the head entry. Entries are kept in
// descending priority; equal priorities leave in arrival order.
// Every request produces exactly one result transfer on the rsp_ channel:
// the removed entry (served_valid high) or zeros, the occupancy after the
// request, and a status (ok, remove while empty, insert dropped when full).
// With no stall, a request passes the decode register and the two-entry
// command queue; the slot array then updates all QUEUE_DEPTH slots in
// parallel and registers the result. Sustained throughput is one request
// per cycle while rsp_ready is high, set by the slot array.
// When the receiver holds rsp_ready low, the result register holds, the
// command queue fills and then req_ready drops; nothing is lost.
// Reset (synchronous, active high) empties the queue and all pipeline
// stages; it needs no clearing pass.
module stable_priority_queue_top #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_type,
   input  logic [spq_pkg::TAG_W-1:0]   req_entry_tag,
   input  logic [spq_pkg::AGE_W-1:0]   req_entry_age,
   input  logic [spq_pkg::PRIO_W-1:0]  req_entry_priority,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_served_valid,
   output logic [spq_pkg::TAG_W-1:0]   rsp_served_tag,
   output logic [spq_pkg::AGE_W-1:0]   rsp_served_age,
   output logic [spq_pkg::PRIO_W-1:0]  rsp_served_priority,
   output logic [spq_pkg::OCC_W-1:0]   rsp_occupancy,
   output logic [spq_pkg::STAT_W-1:0]  rsp_status
);

   logic             dec_valid, dec_ready;
   spq_pkg::cmd_type dec_cmd;
   logic             exe_valid, exe_ready;
   spq_pkg::cmd_type exe_cmd;

   spq_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_entry_tag      (req_entry_tag),
      .req_entry_age      (req_entry_age),
      .req_entry_priority (req_entry_priority),
      .cmd_valid          (dec_valid),
      .cmd_ready          (dec_ready),
      .cmd                (dec_cmd)
   );

   spq_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_cmd    (dec_cmd),
      .out_valid (exe_valid),
      .out_ready (exe_ready),
      .out_cmd   (exe_cmd)
   );

   spq_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .cmd_valid           (exe_valid),
      .cmd_ready           (exe_ready),
      .cmd                 (exe_cmd),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_served_valid    (rsp_served_valid),
      .rsp_served_tag      (rsp_served_tag),
      .rsp_served_age      (rsp_served_age),
      .rsp_served_priority (rsp_served_priority),
      .rsp_occupancy       (rsp_occupancy),
      .rsp_status          (rsp_status)
   );

endmodule
